// ===== design/ssnf_pkg.sv =====
// Shared types, constants and the segment code table of the number framer.
`timescale 1ns / 1ps

package ssnf_pkg;

    // Largest number of digit positions the display offers.
    localparam int MAX_DIGITS = 4;
    localparam int LEN_W      = 3;
    localparam int NUM_W      = 16;
    localparam int CFG_ADDR_W = 3;

    // Command bytes of the display controller.
    localparam logic [7:0] CMD_DATA_MODE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS   = 8'hC0;
    localparam logic [7:0] CMD_CONTROL   = 8'h80;

    // Special segment patterns.
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Division by ten as a multiply by a scaled reciprocal, exact for 16-bit values.
    localparam logic [31:0] RECIP_TEN   = 32'd52429;
    localparam int          RECIP_SHIFT = 19;

    // Requested display operation.
    typedef enum logic [1:0] {
        OP_DECIMAL  = 2'd0,
        OP_HEX      = 2'd1,
        OP_RAW      = 2'd2,
        OP_RESERVED = 2'd3
    } t_op;

    // Configuration register selected by address bit 2.
    typedef enum logic {
        REG_BRIGHTNESS = 1'b0,
        REG_DISPLAY_ON = 1'b1
    } t_reg;

    // Configuration values used when the control frame is built.
    typedef struct packed {
        logic [2:0] brightness;
        logic       display_on;
    } t_cfg;

    // Item state while its digits are extracted.
    typedef struct packed {
        logic                         is_raw;
        logic                         is_hex;
        logic                         negative;
        logic                         lead_zeros;
        logic [LEN_W-1:0]             len;
        logic [1:0]                   pos;
        logic [MAX_DIGITS-1:0]        dots;
        logic [MAX_DIGITS-1:0][7:0]   raw;
        logic [NUM_W-1:0]             rem;
        logic [1:0]                   idx;
        logic [MAX_DIGITS-1:0][3:0]   digit;
        logic [MAX_DIGITS-1:0]        zero;
    } t_work;

    // Finished frame content, segment bytes in display position order.
    typedef struct packed {
        logic [LEN_W-1:0]           len;
        logic [1:0]                 pos;
        logic [MAX_DIGITS-1:0][7:0] seg;
    } t_frame;

    // Seven-segment code of one hexadecimal digit, segment A in bit 0.
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] code;
        case (d)
            4'h0: code = 8'h3F;
            4'h1: code = 8'h06;
            4'h2: code = 8'h5B;
            4'h3: code = 8'h4F;
            4'h4: code = 8'h66;
            4'h5: code = 8'h6D;
            4'h6: code = 8'h7D;
            4'h7: code = 8'h07;
            4'h8: code = 8'h7F;
            4'h9: code = 8'h6F;
            4'hA: code = 8'h77;
            4'hB: code = 8'h7C;
            4'hC: code = 8'h39;
            4'hD: code = 8'h5E;
            4'hE: code = 8'h79;
            4'hF: code = 8'h71;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== design/ssnf_decode.sv =====
// Input stage: clamps the digit count, forms the magnitude and drops unused operations.
`timescale 1ns / 1ps

module ssnf_decode #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_operation,
    input  logic [15:0]           i_number,
    input  logic [7:0]            i_dot_mask,
    input  logic                  i_leading_zeros,
    input  logic [2:0]            i_digit_count,
    input  logic [1:0]            i_start_position,
    input  logic [7:0]            i_raw_seg0,
    input  logic [7:0]            i_raw_seg1,
    input  logic [7:0]            i_raw_seg2,
    input  logic [7:0]            i_raw_seg3,
    output logic                  o_valid,
    output ssnf_pkg::t_work       o_data,
    input  logic                  i_ready
);
    import ssnf_pkg::*;

    logic  r_valid;
    t_work r_data;
    t_work n_data;
    logic  keep;

    // The stage takes a beat when it is empty or its beat moves on.
    assign o_ready = !r_valid || i_ready;
    assign keep    = (i_operation != OP_RESERVED);

    // Build the working record of the item.
    always_comb begin
        n_data            = '0;
        n_data.is_raw     = (i_operation == OP_RAW);
        n_data.is_hex     = (i_operation == OP_HEX);
        n_data.negative   = (i_operation == OP_DECIMAL) && i_number[15];
        n_data.lead_zeros = i_leading_zeros;
        n_data.pos        = i_start_position;
        n_data.raw        = {i_raw_seg3, i_raw_seg2, i_raw_seg1, i_raw_seg0};
        n_data.rem        = n_data.negative ? NUM_W'(16'd0 - i_number) : i_number;
        if (i_digit_count == 3'd0) begin
            n_data.len = LEN_W'(1);
        end else if (i_digit_count > LEN_W'(NUM_DIGITS)) begin
            n_data.len = LEN_W'(NUM_DIGITS);
        end else begin
            n_data.len = i_digit_count;
        end
        // Dot of display position i comes from mask bit 7-i.
        for (int i = 0; i < MAX_DIGITS; i++) begin
            n_data.dots[i] = i_dot_mask[7-i];
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && keep;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/ssnf_digit_stage.sv =====
// One digit extraction step: divides the remainder by the base and stores one digit.
`timescale 1ns / 1ps

module ssnf_digit_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ssnf_pkg::t_work i_data,
    output logic            o_valid,
    output ssnf_pkg::t_work o_data,
    input  logic            i_ready
);
    import ssnf_pkg::*;

    logic             r_valid;
    t_work            r_data;
    t_work            n_data;
    logic [31:0]      prod;
    logic [NUM_W-1:0] quot;
    logic [3:0]       ten_q;
    logic [3:0]       dig;

    assign o_ready = !r_valid || i_ready;

    // Quotient by reciprocal multiply in decimal, by shift in hex. The digit
    // is below the base, so the low four bits of rem - base*quot are enough.
    always_comb begin
        prod  = {16'b0, i_data.rem} * RECIP_TEN;
        quot  = i_data.is_hex ? {4'b0, i_data.rem[15:4]}
                              : NUM_W'(prod[31:RECIP_SHIFT]);
        ten_q = 4'({quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0});
        dig   = i_data.is_hex ? i_data.rem[3:0] : 4'(i_data.rem[3:0] - ten_q);

        n_data                   = i_data;
        n_data.rem               = quot;
        n_data.digit[i_data.idx] = dig;
        n_data.zero[i_data.idx]  = (i_data.rem == '0);
        n_data.idx               = 2'(i_data.idx + 2'd1);
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/ssnf_encode.sv =====
// Segment encoder: blanking, minus sign, dots and raw bytes, in display position order.
`timescale 1ns / 1ps

module ssnf_encode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ssnf_pkg::t_work  i_data,
    output logic             o_valid,
    output ssnf_pkg::t_frame o_data,
    input  logic             i_ready
);
    import ssnf_pkg::*;

    logic                       r_valid;
    t_frame                     r_data;
    t_frame                     n_data;
    logic [MAX_DIGITS-1:0][7:0] by_digit;
    logic                       lone_zero;
    logic [LEN_W-1:0]           j;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // A zero value with blanking on shows one zero in the rightmost place.
        lone_zero = i_data.zero[0] && !i_data.lead_zeros;

        // Patterns indexed by digit order, rightmost digit first.
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (lone_zero) begin
                by_digit[d] = (d == 0) ? seg_code(4'h0) : SEG_BLANK;
            end else if (i_data.negative && i_data.zero[d]
                         && ((d == 0) || !i_data.zero[(d == 0) ? 0 : d-1])) begin
                // The minus sign takes the first position with nothing left to show.
                by_digit[d] = SEG_MINUS;
            end else if (i_data.zero[d] && !i_data.lead_zeros) begin
                by_digit[d] = SEG_BLANK;
            end else begin
                by_digit[d] = seg_code(i_data.digit[d]);
            end
        end

        // Map to display positions, leftmost first, and add the dots.
        n_data     = '0;
        n_data.len = i_data.len;
        n_data.pos = i_data.pos;
        j          = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            j = LEN_W'(i_data.len - LEN_W'(1) - LEN_W'(i));
            if (LEN_W'(i) < i_data.len) begin
                n_data.seg[i] = i_data.is_raw ? i_data.raw[i]
                                : (by_digit[j[1:0]] | {i_data.dots[i], 7'b0});
            end
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/ssnf_serializer.sv =====
// Byte serializer: frame record to command byte stream, one beat a cycle unless stalled.
`timescale 1ns / 1ps

module ssnf_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ssnf_pkg::t_frame i_data,
    input  ssnf_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output logic [7:0]       o_wire_byte,
    output logic             o_frame_start,
    output logic             o_frame_end,
    output logic             o_last_byte,
    input  logic             i_stall
);
    import ssnf_pkg::*;

    // Byte slots within one item's stream.
    localparam logic [2:0] SLOT_DATA_MODE = 3'd0;
    localparam logic [2:0] SLOT_ADDRESS   = 3'd1;
    localparam logic [2:0] SLOT_FIRST_SEG = 3'd2;

    t_frame     r_frame;
    logic       r_full;
    logic [2:0] r_k;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_fs;
    logic       r_fe;
    logic       r_lb;

    logic       out_free;
    logic       last;
    logic [2:0] seg_idx;
    logic [7:0] n_byte;
    logic       n_fs;
    logic       n_fe;

    // The output register frees when empty or when its beat is taken.
    assign out_free = !r_out_valid || !i_stall;
    assign last     = (r_k == 3'(r_frame.len + 3'd2));
    assign o_ready  = !r_full || (out_free && last);

    // Select the byte for the current slot.
    always_comb begin
        seg_idx = 3'(r_k - SLOT_FIRST_SEG);
        n_byte  = r_frame.seg[seg_idx[1:0]];
        n_fs    = 1'b0;
        n_fe    = (r_k == 3'(r_frame.len + 3'd1));
        if (r_k == SLOT_DATA_MODE) begin
            n_byte = CMD_DATA_MODE;
            n_fs   = 1'b1;
            n_fe   = 1'b1;
        end else if (r_k == SLOT_ADDRESS) begin
            n_byte = CMD_ADDRESS | {6'b0, r_frame.pos};
            n_fs   = 1'b1;
            n_fe   = 1'b0;
        end else if (last) begin
            n_byte = CMD_CONTROL | {4'b0, i_cfg.display_on, i_cfg.brightness};
            n_fs   = 1'b1;
            n_fe   = 1'b1;
        end
    end

    // Holding register state and slot counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_k         <= SLOT_DATA_MODE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_full;
            end
            if (out_free && r_full) begin
                r_k <= last ? SLOT_DATA_MODE : 3'(r_k + 3'd1);
            end
            // A new frame refills the holding register as the last byte leaves.
            if (o_ready && i_valid) begin
                r_full <= 1'b1;
            end else if (out_free && r_full && last) begin
                r_full <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= i_data;
        end
        if (out_free && r_full) begin
            r_byte <= n_byte;
            r_fs   <= n_fs;
            r_fe   <= n_fe;
            r_lb   <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_wire_byte   = r_byte;
    assign o_frame_start = r_fs;
    assign o_frame_end   = r_fe;
    assign o_last_byte   = r_lb;

`ifndef SYNTHESIS
    // The control byte closing an item is framed on both sides.
    a_last_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_lb |-> r_fs && r_fe)
        else $error("last byte without start and stop condition");

    // The slot counter never passes the control byte of the held item.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_k <= 3'(r_frame.len + 3'd2)))
        else $error("slot counter beyond end of item");

    // A held item always has between one and four segment bytes.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_frame.len >= 3'd1) && (r_frame.len <= 3'(MAX_DIGITS)))
        else $error("digit count out of range");

    // Inside an item the stream does not pause.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_stall && !r_lb |=> r_out_valid)
        else $error("gap inside an item's byte stream");

    // After an item ends, the next beat opens a new item.
    a_new_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_stall && r_lb |=>
            !r_out_valid || ((r_byte == CMD_DATA_MODE) && r_fs && r_fe))
        else $error("item does not open with the data mode command");
`endif

endmodule

// ===== design/seven_segment_number_framer_core.sv =====
// Top level of the seven-segment number framer: config registers and the stage chain.
`timescale 1ns / 1ps

// Usage:
// Each input beat (i_valid high, o_stall low) asks for a signed decimal, hex or
// raw display update. The output channel (o_valid, i_stall) carries the command
// bytes for the display controller: the data mode command, the address command,
// one segment byte per digit position and the control command, with start and
// stop condition flags and a flag on the final byte of each request.
// Brightness and display on are set through the APB port (offsets 0 and 4).
// Path: the first byte of a request passes the decode stage, one divide-by-base
// stage per digit, the encoder, the serializer holding register and the output
// register.
// Throughput: a request sends its clamped digit count + 3 bytes (4 to 7); the
// serializer, which sends one byte a cycle while i_stall is low, sets the rate.
// New requests enter the stage chain while earlier ones are still being sent.
// A request with operation 3 is dropped in the decode stage and sends nothing.
// Reset clears all valid bits and the configuration registers.
// While the receiver stalls, the output beat holds and the stages fill up, then
// o_stall rises; no beat is lost or repeated.

module seven_segment_number_framer_core #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_operation,
    input  logic [15:0]                        i_number,
    input  logic [7:0]                         i_dot_mask,
    input  logic                               i_leading_zeros,
    input  logic [2:0]                         i_digit_count,
    input  logic [1:0]                         i_start_position,
    input  logic [7:0]                         i_raw_seg0,
    input  logic [7:0]                         i_raw_seg1,
    input  logic [7:0]                         i_raw_seg2,
    input  logic [7:0]                         i_raw_seg3,
    // Byte channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_wire_byte,
    output logic                               o_frame_start,
    output logic                               o_frame_end,
    output logic                               o_last_byte,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssnf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ssnf_pkg::*;

    logic [2:0] r_brightness;
    logic       r_display_on;
    logic       cfg_write;
    t_cfg       cfg;

    logic   dec_ready;
    logic   chain_valid [NUM_DIGITS+1];
    t_work  chain_data  [NUM_DIGITS+1];
    logic   chain_ready [NUM_DIGITS+1];
    logic   enc_valid;
    logic   enc_ready;
    t_frame enc_data;
    logic   ser_ready;

    // Configuration registers, selected by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= 3'd0;
            r_display_on <= 1'b0;
        end else if (cfg_write) begin
            case (t_reg'(paddr[2]))
                REG_BRIGHTNESS: r_brightness <= pwdata[2:0];
                REG_DISPLAY_ON: r_display_on <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_BRIGHTNESS: prdata = {29'b0, r_brightness};
            REG_DISPLAY_ON: prdata = {31'b0, r_display_on};
            default:        prdata = '0;
        endcase
    end

    assign cfg.brightness = r_brightness;
    assign cfg.display_on = r_display_on;

    // Decode stage.
    assign o_stall = !dec_ready;

    ssnf_decode #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (dec_ready),
        .i_operation      (i_operation),
        .i_number         (i_number),
        .i_dot_mask       (i_dot_mask),
        .i_leading_zeros  (i_leading_zeros),
        .i_digit_count    (i_digit_count),
        .i_start_position (i_start_position),
        .i_raw_seg0       (i_raw_seg0),
        .i_raw_seg1       (i_raw_seg1),
        .i_raw_seg2       (i_raw_seg2),
        .i_raw_seg3       (i_raw_seg3),
        .o_valid          (chain_valid[0]),
        .o_data           (chain_data[0]),
        .i_ready          (chain_ready[0])
    );

    // One divide-by-base stage per digit position.
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
        ssnf_digit_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1]),
            .i_ready (chain_ready[g+1])
        );
    end

    // Segment encoder.
    assign chain_ready[NUM_DIGITS] = enc_ready;

    ssnf_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[NUM_DIGITS]),
        .o_ready (enc_ready),
        .i_data  (chain_data[NUM_DIGITS]),
        .o_valid (enc_valid),
        .o_data  (enc_data),
        .i_ready (ser_ready)
    );

    // Byte serializer and output register.
    ssnf_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (enc_valid),
        .o_ready       (ser_ready),
        .i_data        (enc_data),
        .i_cfg         (cfg),
        .o_valid       (o_valid),
        .o_wire_byte   (o_wire_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last_byte   (o_last_byte),
        .i_stall       (i_stall)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the seven-segment number framer core.
`timescale 1ns / 1ps

module tb;
    import ssnf_pkg::*;

    localparam int          DIGITS        = 4;
    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 9;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          PHASE_ITEMS   = 105;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          REPORT_LIMIT  = 10;

    // Register offsets on the configuration port.
    localparam logic [2:0]  ADDR_BRIGHTNESS = 3'd0;
    localparam logic [2:0]  ADDR_DISPLAY_ON = 3'd4;

    // Display controller command bytes and special glyphs.
    localparam logic [7:0]  BYTE_DATA_MODE = 8'h40;
    localparam logic [7:0]  BYTE_ADDRESS   = 8'hC0;
    localparam logic [7:0]  BYTE_CONTROL   = 8'h80;
    localparam logic [7:0]  GLYPH_MINUS    = 8'h40;
    localparam logic [7:0]  GLYPH_BLANK    = 8'h00;

    // Segment patterns of the hex digits, segment A in bit 0.
    localparam logic [7:0] GLYPHS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    localparam logic [0:3][7:0] NO_RAW = '0;

    // One display request as it enters the block.
    typedef struct {
        t_op             op;
        logic [15:0]     number;
        logic [7:0]      dots;
        logic            lz;
        logic [2:0]      count;
        logic [1:0]      pos;
        logic [0:3][7:0] raw;
    } t_req;

    // One byte beat on the output channel.
    typedef struct {
        logic [7:0] data;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_wire_beat;

    // Directed row: a request and, where typed, its segment bytes.
    typedef struct {
        t_req            req;
        bit              typed;
        int              seg_len;
        logic [0:3][7:0] segs;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [1:0]             i_operation = '0;
    logic [15:0]            i_number = '0;
    logic [7:0]             i_dot_mask = '0;
    logic                   i_leading_zeros = 1'b0;
    logic [2:0]             i_digit_count = '0;
    logic [1:0]             i_start_position = '0;
    logic [7:0]             i_raw_seg0 = '0;
    logic [7:0]             i_raw_seg1 = '0;
    logic [7:0]             i_raw_seg2 = '0;
    logic [7:0]             i_raw_seg3 = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [7:0]             o_wire_byte;
    logic                   o_frame_start;
    logic                   o_frame_end;
    logic                   o_last_byte;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    t_wire_beat bytes_due [$];
    t_row       directed_rows [23];
    logic [2:0] shadow_brightness = '0;
    logic       shadow_display_on = 1'b0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         requests_sent = 0;
    int         requests_ignored = 0;
    int         beats_checked = 0;
    int         settings_used = 1;

    seven_segment_number_framer_core #(
        .NUM_DIGITS (DIGITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_number         (i_number),
        .i_dot_mask       (i_dot_mask),
        .i_leading_zeros  (i_leading_zeros),
        .i_digit_count    (i_digit_count),
        .i_start_position (i_start_position),
        .i_raw_seg0       (i_raw_seg0),
        .i_raw_seg1       (i_raw_seg1),
        .i_raw_seg2       (i_raw_seg2),
        .i_raw_seg3       (i_raw_seg3),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_wire_byte      (o_wire_byte),
        .o_frame_start    (o_frame_start),
        .o_frame_end      (o_frame_end),
        .o_last_byte      (o_last_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Counts a failure and reports the first few of them.
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Queues the full command stream for one request with the given segment bytes.
    task automatic queue_frames(input int len, input logic [1:0] pos,
                                input logic [0:3][7:0] segs);
        int i;
        bytes_due.push_back('{BYTE_DATA_MODE, 1'b1, 1'b1, 1'b0});
        bytes_due.push_back('{BYTE_ADDRESS | {6'd0, pos}, 1'b1, 1'b0, 1'b0});
        for (i = 0; i < len; i++) begin
            bytes_due.push_back('{segs[i], 1'b0, i == len - 1, 1'b0});
        end
        bytes_due.push_back('{BYTE_CONTROL | {4'd0, shadow_display_on, shadow_brightness},
                              1'b1, 1'b1, 1'b1});
    endtask

    // Works out the segment bytes of a request and queues its command stream.
    task automatic predict_command_bytes(input t_req r);
        logic [0:3][7:0] segs;
        int unsigned     len;
        int unsigned     val;
        int unsigned     radix;
        int unsigned     dig;
        bit              minus_due;
        int              i;
        if (r.op == OP_RESERVED) begin
            requests_ignored++;
            return;
        end
        len = (r.count < 1) ? 1 : ((r.count > DIGITS) ? DIGITS : r.count);
        segs = r.raw;
        if (r.op != OP_RAW) begin
            val = r.number;
            radix = (r.op == OP_HEX) ? 16 : 10;
            minus_due = 1'b0;
            // Decimal mode shows the magnitude of a negative value.
            if (r.op == OP_DECIMAL && r.number[15]) begin
                minus_due = 1'b1;
                val = 32'h10000 - val;
            end
            segs = '0;
            if (val == 0 && !r.lz) begin
                segs[len - 1] = GLYPHS[0];
            end else begin
                // Digits from the right; the minus sign takes the first empty position.
                for (i = len - 1; i >= 0; i--) begin
                    dig = val % radix;
                    if (dig == 0 && val == 0 && !r.lz) begin
                        segs[i] = GLYPH_BLANK;
                    end else begin
                        segs[i] = GLYPHS[dig];
                    end
                    if (dig == 0 && val == 0 && minus_due) begin
                        segs[i] = GLYPH_MINUS;
                        minus_due = 1'b0;
                    end
                    val = val / radix;
                end
            end
            // Dot mask, most significant bit on the leftmost digit.
            for (i = 0; i < len; i++) begin
                segs[i][7] = segs[i][7] | r.dots[7 - i];
            end
        end
        queue_frames(len, r.pos, segs);
    endtask

    // Presents one request and waits for its beat to be taken.
    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= r.op;
        i_number         <= r.number;
        i_dot_mask       <= r.dots;
        i_leading_zeros  <= r.lz;
        i_digit_count    <= r.count;
        i_start_position <= r.pos;
        i_raw_seg0       <= r.raw[0];
        i_raw_seg1       <= r.raw[1];
        i_raw_seg2       <= r.raw[2];
        i_raw_seg3       <= r.raw[3];
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    // A setup and an access phase on the configuration port, then the bus goes idle.
    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes a register, updates the shadow copy and reads the value back.
    task automatic write_setting(input logic [2:0] addr, input logic [31:0] value,
                                 input logic [31:0] mask);
        logic [31:0] rdata;
        apb_access(1'b1, addr, value, rdata);
        if (addr == ADDR_BRIGHTNESS) begin
            shadow_brightness = value[2:0];
        end else begin
            shadow_display_on = value[0];
        end
        apb_access(1'b0, addr, '0, rdata);
        if ((rdata & mask) !== (value & mask)) begin
            note_failure($sformatf("register %0d read back %h, expected %h",
                                   addr, rdata & mask, value & mask));
        end
    endtask

    // Waits until every expected byte has arrived and the pipeline is quiet.
    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random request, weighted toward small values, sign edges and legal counts.
    function automatic t_req random_request();
        t_req r;
        r.op = ($urandom_range(0, 99) < 4) ? OP_RESERVED : t_op'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0: r.number = 16'($urandom_range(0, 20));
            1: r.number = 16'($urandom);
            2: r.number = 16'hFFFF - 16'($urandom_range(0, 20));
            3: r.number = 16'h7FFE + 16'($urandom_range(0, 3));
            4: r.number = 16'($urandom_range(0, 9999));
            default: r.number = 16'($urandom_range(0, 255)) << 4;
        endcase
        r.dots  = 8'($urandom);
        r.lz    = 1'($urandom);
        r.count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
        r.pos   = 2'($urandom);
        r.raw   = 32'($urandom);
        return r;
    endfunction

    // One random phase with its own register setting and idle profile.
    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input logic [2:0] brightness, input logic on);
        t_req r;
        int   counted;
        drain_outputs();
        write_setting(ADDR_BRIGHTNESS, {29'd0, brightness}, 32'h7);
        write_setting(ADDR_DISPLAY_ON, {31'd0, on}, 32'h1);
        settings_used++;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            r = random_request();
            send_request(r);
            predict_command_bytes(r);
            if (r.op != OP_RESERVED) begin
                counted++;
            end
        end
    endtask

    // Output checking, receiver stall and run limit.
    always @(posedge i_clk) begin
        t_wire_beat want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            beats_checked++;
            if (bytes_due.size() == 0) begin
                note_failure($sformatf("unexpected beat byte=%h fs=%b fe=%b last=%b",
                                       o_wire_byte, o_frame_start, o_frame_end,
                                       o_last_byte));
            end else begin
                want = bytes_due.pop_front();
                if (o_wire_byte !== want.data || o_frame_start !== want.frame_start ||
                    o_frame_end !== want.frame_end || o_last_byte !== want.last) begin
                    note_failure($sformatf(
                        "expected byte=%h fs=%b fe=%b last=%b, got byte=%h fs=%b fe=%b last=%b",
                        want.data, want.frame_start, want.frame_end, want.last,
                        o_wire_byte, o_frame_start, o_frame_end, o_last_byte));
                end
            end
        end
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Stimulus sequence.
    initial begin
        int k;
        // Directed rows; typed rows assume the reset register values.
        directed_rows[0]  = '{'{OP_HEX, 16'h0000, 8'h00, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b1, 4, {8'h00, 8'h00, 8'h00, 8'h3F}};
        directed_rows[1]  = '{'{OP_HEX, 16'hFFFF, 8'hF0, 1'b1, 3'd4, 2'd3, NO_RAW},
                              1'b1, 4, {8'hF1, 8'hF1, 8'hF1, 8'hF1}};
        directed_rows[2]  = '{'{OP_DECIMAL, 16'h0000, 8'h00, 1'b1, 3'd4, 2'd1, NO_RAW},
                              1'b1, 4, {8'h3F, 8'h3F, 8'h3F, 8'h3F}};
        directed_rows[3]  = '{'{OP_DECIMAL, 16'h8000, 8'h00, 1'b0, 3'd4, 2'd2, NO_RAW},
                              1'b1, 4, {8'h5B, 8'h07, 8'h7D, 8'h7F}};
        directed_rows[4]  = '{'{OP_DECIMAL, 16'hFFFF, 8'h00, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b1, 4, {8'h00, 8'h00, 8'h40, 8'h06}};
        directed_rows[5]  = '{'{OP_DECIMAL, 16'hFFFF, 8'h00, 1'b1, 3'd4, 2'd0, NO_RAW},
                              1'b1, 4, {8'h3F, 8'h3F, 8'h40, 8'h06}};
        directed_rows[6]  = '{'{OP_DECIMAL, 16'h270F, 8'h00, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b1, 4, {8'h6F, 8'h6F, 8'h6F, 8'h6F}};
        directed_rows[7]  = '{'{OP_DECIMAL, 16'h3039, 8'h00, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b1, 4, {8'h5B, 8'h4F, 8'h66, 8'h6D}};
        directed_rows[8]  = '{'{OP_RAW, 16'h0000, 8'hFF, 1'b0, 3'd4, 2'd1,
                                {8'h00, 8'hFF, 8'hA5, 8'h5A}},
                              1'b1, 4, {8'h00, 8'hFF, 8'hA5, 8'h5A}};
        directed_rows[9]  = '{'{OP_RESERVED, 16'hFFFF, 8'hFF, 1'b1, 3'd7, 2'd3,
                                {8'hFF, 8'hFF, 8'hFF, 8'hFF}},
                              1'b1, 0, NO_RAW};
        directed_rows[10] = '{'{OP_DECIMAL, 16'h0007, 8'h00, 1'b0, 3'd0, 2'd0, NO_RAW},
                              1'b1, 1, {8'h07, 8'h00, 8'h00, 8'h00}};
        directed_rows[11] = '{'{OP_HEX, 16'h1234, 8'h00, 1'b0, 3'd7, 2'd0, NO_RAW},
                              1'b1, 4, {8'h06, 8'h5B, 8'h4F, 8'h66}};
        directed_rows[12] = '{'{OP_HEX, 16'h00A0, 8'h00, 1'b0, 3'd3, 2'd0, NO_RAW},
                              1'b1, 3, {8'h00, 8'h77, 8'h3F, 8'h00}};
        directed_rows[13] = '{'{OP_DECIMAL, 16'hFFFB, 8'h00, 1'b0, 3'd1, 2'd0, NO_RAW},
                              1'b1, 1, {8'h6D, 8'h00, 8'h00, 8'h00}};
        directed_rows[14] = '{'{OP_DECIMAL, 16'hFFFB, 8'h00, 1'b0, 3'd2, 2'd1, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[15] = '{'{OP_HEX, 16'h0000, 8'h80, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[16] = '{'{OP_RAW, 16'h5555, 8'h0F, 1'b1, 3'd2, 2'd2,
                                {8'h12, 8'h34, 8'h56, 8'h78}},
                              1'b0, 0, NO_RAW};
        directed_rows[17] = '{'{OP_DECIMAL, 16'h0000, 8'h00, 1'b0, 3'd2, 2'd3, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[18] = '{'{OP_DECIMAL, 16'h7FFF, 8'h00, 1'b0, 3'd4, 2'd0, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[19] = '{'{OP_HEX, 16'hABCD, 8'h50, 1'b1, 3'd5, 2'd2, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[20] = '{'{OP_DECIMAL, 16'h8001, 8'hA0, 1'b1, 3'd6, 2'd1, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[21] = '{'{OP_RESERVED, 16'h1234, 8'h00, 1'b0, 3'd2, 2'd0, NO_RAW},
                              1'b0, 0, NO_RAW};
        directed_rows[22] = '{'{OP_HEX, 16'h00EF, 8'h30, 1'b0, 3'd4, 2'd3, NO_RAW},
                              1'b0, 0, NO_RAW};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values.
        tx_idle_pct  = 25;
        rx_stall_pct = 79;
        for (k = 0; k < $size(directed_rows); k++) begin
            send_request(directed_rows[k].req);
            if (!directed_rows[k].typed) begin
                predict_command_bytes(directed_rows[k].req);
            end else if (directed_rows[k].seg_len == 0) begin
                requests_ignored++;
            end else begin
                queue_frames(directed_rows[k].seg_len, directed_rows[k].req.pos,
                             directed_rows[k].segs);
            end
        end

        // Random phases: slow receiver, then slow sender, then full rate.
        run_random_phase(25, 79, 3'd7, 1'b1);
        run_random_phase(79, 25, 3'd3, 1'b0);
        run_random_phase(0, 0, 3'd0, 1'b1);
        drain_outputs();

        if (bytes_due.size() != 0) begin
            note_failure($sformatf("%0d expected bytes never arrived", bytes_due.size()));
        end
        $display("Sent %0d requests (%0d ignored) and checked %0d output bytes",
                 requests_sent, requests_ignored, beats_checked);
        $display("across %0d register settings and three idle profiles; %0d failures",
                 settings_used, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
